// ===== design/cic_pkg.sv =====
package cic_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEL
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic select;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_full;
      logic out_taken;
   } dp_status_type;

   localparam logic [2:0] REQ_LINE  = 3'd0;
   localparam logic [2:0] REQ_READ  = 3'd1;
   localparam logic [2:0] REQ_WRITE = 3'd2;
   localparam logic [2:0] REQ_ACK   = 3'd3;
   localparam logic [2:0] REQ_PEEK  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;
   localparam logic [1:0] ST_NONE    = 2'd3;

   localparam logic [15:0] PORT_MCMD  = 16'h0020;
   localparam logic [15:0] PORT_MDATA = 16'h0021;
   localparam logic [15:0] PORT_SCMD  = 16'h00a0;
   localparam logic [15:0] PORT_SDATA = 16'h00a1;
   localparam logic [15:0] PORT_MELCR = 16'h04d0;
   localparam logic [15:0] PORT_SELCR = 16'h04d1;

   localparam int F_RRS   = 0;
   localparam int F_POLL  = 1;
   localparam int F_SMM   = 2;
   localparam int F_AEOI  = 3;
   localparam int F_RAEOI = 4;
   localparam int F_SFNM  = 5;
   localparam int F_IC4   = 6;

   localparam logic [7:0] POLL_CASCADE = 8'h82;
   localparam logic [7:0] POLL_HIT     = 8'h80;
   localparam logic [7:0] BASE_MASK    = 8'hf8;
   localparam logic [7:0] CASCADE_BIT  = 8'h04;

   // first set bit in rotating priority order, {found, line}
   function automatic logic [3:0] scan8(input logic [2:0] off, input logic [7:0] bits);
      logic [3:0] res;
      logic [2:0] irq;
      res = 4'd0;
      for (int k = 7; k >= 0; k--) begin
         irq = off + 3'(k);
         if (bits[irq]) res = {1'b1, irq};
      end
      return res;
   endfunction

   function automatic logic [3:0] top_service(input logic [2:0] off, input logic [7:0] isr,
                                             input logic [7:0] imr, input logic smm);
      return scan8(off, smm ? (isr & ~imr) : isr);
   endfunction

   function automatic logic [3:0] next_of(input logic [2:0] off, input logic [7:0] req,
                                         input logic [7:0] imr, input logic [7:0] isr,
                                         input logic smm);
      logic [3:0] p;
      logic [3:0] s;
      logic [2:0] rp;
      logic [2:0] rs;
      p  = scan8(off, req & ~imr);
      s  = top_service(off, isr, imr, smm);
      rp = p[2:0] - off;
      rs = s[2:0] - off;
      if (!p[3]) return 4'd0;
      if (s[3] && rp >= rs) return 4'd0;
      return p;
   endfunction

endpackage

// ===== design/cic_ctl.sv =====
module cic_ctl
   import cic_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type dp_status,
   output ctl_cmd_type   cmd
);

   ctl_state_type state_ff, state_in;
   logic          out_free;

   assign out_free = !dp_status.out_full || dp_status.out_taken;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_SEL;
         ST_SEL:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            // nothing is taken while reset is held
            req_tready = !reset;
            cmd.load   = req_tvalid && !reset;
         end
         ST_EXEC: cmd.exec = 1'b1;
         ST_SEL:  cmd.select = out_free;
         default: ;
      endcase
   end

endmodule

// ===== design/cic_dp.sv =====
module cic_dp
   import cic_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   output dp_status_type dp_status,
   input  logic [39:0]   req_tdata,
   input  logic [7:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [23:0]   rsp_tdata,
   output logic [7:0]    rsp_tuser,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [7:0]    csr_wdata
);

   // captured request
   logic [2:0]  type_ff;
   logic [3:0]  line_ff;
   logic        level_ff;
   logic [15:0] port_ff;
   logic [3:0]  bytes_ff;
   logic        strrep_ff;
   logic [7:0]  wdata_ff;

   logic [7:0] mlm_ff, slm_ff;

   logic [7:0] req_ff [2], req_in [2];
   logic [7:0] seen_ff [2], seen_in [2];
   logic [7:0] imr_ff [2], imr_in [2];
   logic [7:0] isr_ff [2], isr_in [2];
   logic [7:0] elcr_ff [2], elcr_in [2];
   logic [7:0] base_ff [2], base_in [2];
   logic [2:0] off_ff [2], off_in [2];
   logic [1:0] step_ff [2], step_in [2];
   logic [6:0] mode_ff [2], mode_in [2];

   // work left for the select phase
   logic       p_sel_ff, p_sel_in;
   logic       p_ack_ff, p_ack_in;
   logic       p_poll_ff, p_poll_in;
   logic       p_chip_ff, p_chip_in;
   logic       p_report_ff, p_report_in;
   logic       p_none_ff, p_none_in;
   logic [1:0] p_status_ff, p_status_in;
   logic [7:0] p_rdata_ff, p_rdata_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_rdata_ff, rsp_rdata_in;
   logic       rsp_vvalid_ff, rsp_vvalid_in;
   logic [7:0] rsp_vector_ff, rsp_vector_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff   <= req_tuser[2:0];
         line_ff   <= req_tdata[3:0];
         level_ff  <= req_tdata[4];
         port_ff   <= req_tdata[20:5];
         bytes_ff  <= req_tdata[24:21];
         strrep_ff <= req_tdata[25];
         wdata_ff  <= req_tdata[33:26];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mlm_ff <= 8'hf8;
         slm_ff <= 8'hde;
      end else if (csr_we) begin
         if (csr_index) slm_ff <= csr_wdata;
         else mlm_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 2; c++) begin
            req_ff[c]  <= '0;
            seen_ff[c] <= '0;
            imr_ff[c]  <= 8'hff;
            isr_ff[c]  <= '0;
            elcr_ff[c] <= '0;
            off_ff[c]  <= '0;
            step_ff[c] <= '0;
            mode_ff[c] <= '0;
         end
         base_ff[0]   <= 8'h08;
         base_ff[1]   <= 8'h70;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_ff       <= req_in;
         seen_ff      <= seen_in;
         imr_ff       <= imr_in;
         isr_ff       <= isr_in;
         elcr_ff      <= elcr_in;
         base_ff      <= base_in;
         off_ff       <= off_in;
         step_ff      <= step_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_sel_ff      <= p_sel_in;
      p_ack_ff      <= p_ack_in;
      p_poll_ff     <= p_poll_in;
      p_chip_ff     <= p_chip_in;
      p_report_ff   <= p_report_in;
      p_none_ff     <= p_none_in;
      p_status_ff   <= p_status_in;
      p_rdata_ff    <= p_rdata_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_vvalid_ff <= rsp_vvalid_in;
      rsp_vector_ff <= rsp_vector_in;
   end

   logic       chip;
   logic       port_known;
   logic [7:0] bitm;
   logic [7:0] v;
   logic [3:0] eoi_top;
   logic [2:0] eoi_irq;
   logic       eoi_hit;
   logic [3:0] si, mi;
   logic [7:0] req0_eff;
   logic       sel_ok;
   logic       found;
   logic [7:0] vec;
   logic [8:0] slave_hi;
   logic [7:0] vec_rel;

   always_comb begin
      req_in  = req_ff;
      seen_in = seen_ff;
      imr_in  = imr_ff;
      isr_in  = isr_ff;
      elcr_in = elcr_ff;
      base_in = base_ff;
      off_in  = off_ff;
      step_in = step_ff;
      mode_in = mode_ff;

      p_sel_in    = p_sel_ff;
      p_ack_in    = p_ack_ff;
      p_poll_in   = p_poll_ff;
      p_chip_in   = p_chip_ff;
      p_report_in = p_report_ff;
      p_none_in   = p_none_ff;
      p_status_in = p_status_ff;
      p_rdata_in  = p_rdata_ff;

      rsp_status_in = rsp_status_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_vvalid_in = rsp_vvalid_ff;
      rsp_vector_in = rsp_vector_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      v    = wdata_ff;
      chip = (type_ff == REQ_LINE) ? line_ff[3] :
             (port_ff == PORT_SCMD || port_ff == PORT_SDATA);
      port_known = port_ff == PORT_MCMD || port_ff == PORT_MDATA ||
                   port_ff == PORT_SCMD || port_ff == PORT_SDATA ||
                   port_ff == PORT_MELCR || port_ff == PORT_SELCR;
      bitm    = 8'd1 << line_ff[2:0];
      eoi_top = top_service(off_ff[chip], isr_ff[chip], imr_ff[chip], mode_ff[chip][F_SMM]);
      eoi_irq = v[6] ? v[2:0] : eoi_top[2:0];
      eoi_hit = v[6] || eoi_top[3];

      // select: slave first, it feeds master line 2
      sel_ok   = step_ff[0] == 2'd0 && step_ff[1] == 2'd0;
      si       = next_of(off_ff[1], req_ff[1], imr_ff[1], isr_ff[1], mode_ff[1][F_SMM]);
      req0_eff = req_ff[0] | (si[3] ? CASCADE_BIT : 8'd0);
      mi       = next_of(off_ff[0], req0_eff, imr_ff[0], isr_ff[0], mode_ff[0][F_SMM]);
      found    = sel_ok && mi[3];
      vec      = (mi[2:0] != 3'd2 || !si[3]) ? base_ff[0] + {5'd0, mi[2:0]}
                                             : base_ff[1] + {5'd0, si[2:0]};
      slave_hi = {1'b0, base_ff[1]} + 9'd8;
      vec_rel  = vec - base_ff[p_chip_ff];

      if (cmd.exec) begin
         p_sel_in    = 1'b0;
         p_ack_in    = 1'b0;
         p_poll_in   = 1'b0;
         p_chip_in   = chip;
         p_report_in = 1'b0;
         p_none_in   = 1'b0;
         p_status_in = ST_OK;
         p_rdata_in  = '0;
         case (type_ff)
            REQ_LINE: begin
               if (level_ff) begin
                  if ((seen_ff[chip] & bitm) == 8'd0) begin
                     seen_in[chip] = seen_ff[chip] | bitm;
                     req_in[chip]  = req_ff[chip] | bitm;
                  end
               end else begin
                  seen_in[chip] = seen_ff[chip] & ~bitm;
               end
               p_sel_in    = 1'b1;
               p_report_in = 1'b1;
            end
            REQ_READ, REQ_WRITE: begin
               if (!port_known) p_status_in = ST_UNKNOWN;
               else if (strrep_ff || bytes_ff != 4'd1) p_status_in = ST_BAD;
               else if (type_ff == REQ_READ) begin
                  case (port_ff)
                     PORT_MCMD, PORT_SCMD: begin
                        if (mode_ff[chip][F_POLL]) begin
                           mode_in[chip][F_POLL] = 1'b0;
                           p_sel_in  = 1'b1;
                           p_ack_in  = 1'b1;
                           p_poll_in = 1'b1;
                        end else begin
                           p_rdata_in = mode_ff[chip][F_RRS] ? isr_ff[chip] : req_ff[chip];
                        end
                     end
                     PORT_MDATA, PORT_SDATA: p_rdata_in = imr_ff[chip];
                     PORT_MELCR: p_rdata_in = elcr_ff[0];
                     default:    p_rdata_in = elcr_ff[1];
                  endcase
               end else begin
                  case (port_ff)
                     PORT_MCMD, PORT_SCMD: begin
                        if (v[4]) begin
                           // icw1
                           seen_in[chip] = '0;
                           req_in[chip]  = '0;
                           imr_in[chip]  = '0;
                           isr_in[chip]  = '0;
                           off_in[chip]  = '0;
                           mode_in[chip] = mode_ff[chip] & 7'h03;
                           mode_in[chip][F_IC4] = v[0];
                           step_in[chip] = 2'd1;
                        end else if (v[3]) begin
                           // ocw3
                           if (v[2]) mode_in[chip][F_POLL] = 1'b1;
                           if (v[1:0] != 2'd0) mode_in[chip][F_RRS] = v[1];
                           if (v[6]) mode_in[chip][F_SMM] = v[5];
                        end else if (v[5]) begin
                           // eoi, specific or nonspecific
                           if (eoi_hit) begin
                              isr_in[chip] = isr_ff[chip] & ~(8'd1 << eoi_irq);
                              if (v[7]) off_in[chip] = eoi_irq + 3'd1;
                              req_in[chip] = req_ff[chip] | (seen_ff[chip] & elcr_ff[chip]);
                           end
                           p_sel_in    = 1'b1;
                           p_report_in = 1'b1;
                        end else begin
                           case (v[7:6])
                              2'b11:   off_in[chip] = v[2:0] + 3'd1;
                              2'b10:   mode_in[chip][F_RAEOI] = 1'b1;
                              2'b00:   mode_in[chip][F_RAEOI] = 1'b0;
                              default: ;
                           endcase
                        end
                     end
                     PORT_MDATA, PORT_SDATA: begin
                        case (step_ff[chip])
                           2'd0: begin
                              imr_in[chip] = v;
                              p_sel_in     = 1'b1;
                              p_report_in  = 1'b1;
                           end
                           2'd1: begin
                              base_in[chip] = v & BASE_MASK;
                              step_in[chip] = 2'd2;
                           end
                           2'd2: step_in[chip] = mode_ff[chip][F_IC4] ? 2'd3 : 2'd0;
                           default: begin
                              mode_in[chip][F_AEOI] = v[1];
                              mode_in[chip][F_SFNM] = v[4];
                              step_in[chip] = 2'd0;
                              p_sel_in      = 1'b1;
                              p_report_in   = 1'b1;
                           end
                        endcase
                     end
                     PORT_MELCR: begin
                        elcr_in[0]  = v & mlm_ff;
                        p_sel_in    = 1'b1;
                        p_report_in = 1'b1;
                     end
                     default: begin
                        elcr_in[1]  = v & slm_ff;
                        p_sel_in    = 1'b1;
                        p_report_in = 1'b1;
                     end
                  endcase
               end
            end
            REQ_ACK, REQ_PEEK: begin
               p_sel_in    = 1'b1;
               p_ack_in    = type_ff == REQ_ACK;
               p_report_in = 1'b1;
               p_none_in   = 1'b1;
            end
            default: p_status_in = ST_BAD;
         endcase
      end

      if (cmd.select) begin
         if (p_sel_ff && sel_ok) begin
            req_in[0] = req0_eff;
            if (p_ack_ff && found) begin
               req_in[0] = req0_eff & ~(8'd1 << mi[2:0]);
               if (mode_ff[0][F_AEOI]) begin
                  if (mode_ff[0][F_RAEOI]) off_in[0] = mi[2:0] + 3'd1;
               end else begin
                  isr_in[0] = isr_ff[0] | (8'd1 << mi[2:0]);
               end
               if (mi[2:0] == 3'd2 && si[3]) begin
                  req_in[1] = req_ff[1] & ~(8'd1 << si[2:0]);
                  if (mode_ff[1][F_AEOI]) begin
                     if (mode_ff[1][F_RAEOI]) off_in[1] = si[2:0] + 3'd1;
                  end else begin
                     isr_in[1] = isr_ff[1] | (8'd1 << si[2:0]);
                  end
               end
            end
         end
         rsp_valid_in  = 1'b1;
         rsp_status_in = (p_none_ff && !(p_sel_ff && found)) ? ST_NONE : p_status_ff;
         if (p_poll_ff) begin
            if (!found) rsp_rdata_in = 8'd0;
            else if (!p_chip_ff && vec >= base_ff[1] && {1'b0, vec} < slave_hi)
               rsp_rdata_in = POLL_CASCADE;
            else rsp_rdata_in = POLL_HIT | (vec_rel & 8'h07);
         end else begin
            rsp_rdata_in = p_rdata_ff;
         end
         rsp_vvalid_in = p_report_ff && p_sel_ff && found;
         rsp_vector_in = (p_report_ff && p_sel_ff && found) ? vec : 8'd0;
      end
   end

   assign dp_status.out_full  = rsp_valid_ff;
   assign dp_status.out_taken = rsp_valid_ff && rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_vector_ff, rsp_vvalid_ff, rsp_rdata_ff};
   assign rsp_tuser  = {6'd0, rsp_status_ff};

endmodule

// ===== design/cascaded_interrupt_controller.sv =====
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tuser: kind; tdata: line, level, port, size, data
// rsp       out  rsp_tvalid/rsp_tready  tuser: status; tdata: read byte, vector flag, vector
// csr       in   csr_we                 csr_index, csr_wdata (level-trigger masks)
//
// an item passes through three steps from accept to result: capture, execute, priority select
// the select step runs a registered rotating-priority scan of both chips
// reset is synchronous and active high; it restores the power-on chip state
// a stalled result holds in the output register; the next beat may be accepted meanwhile
// and waits in the select step until the output register frees
module cascaded_interrupt_controller
   import cic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // irq_line, line_level, port_address, access_bytes, string_or_repeat, write_data
   input  logic [39:0] req_tdata,
   // req_type
   input  logic [7:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data, vector_valid, vector
   output logic [23:0] rsp_tdata,
   // status
   output logic [7:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   // sequencer: capture, execute, select
   cic_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   // chip registers, command decode, priority resolver and result register
   cic_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

// ===== design/cic_checker.sv =====
module cic_checker
   import cic_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [7:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_vec_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[16:9] == 8'd0)
      else $error("vector set without valid flag");

   a_none_novec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == ST_NONE |-> !rsp_tdata[8])
      else $error("no-interrupt status with a vector");

endmodule

bind cascaded_interrupt_controller cic_checker u_cic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
